// ===== hdl/i2cmts_pkg.sv =====
package i2cmts_pkg;

  // Default sizes handed to the top level.
  localparam int LenWidthDefault   = 16;
  localparam int QueueDepthDefault = 2;

  // Fixed field widths.
  localparam int LenFieldW  = 16;
  localparam int RetriesW   = 4;
  localparam logic [RetriesW-1:0] RetriesReset = 4'd3;

  // Input operation codes.
  typedef enum logic [1:0] {
    OpBeginWrite = 2'd0,
    OpBeginRead  = 2'd1,
    OpDone       = 2'd2,
    OpTimeout    = 2'd3
  } op_e;

  // Event classes after decode.
  typedef enum logic [1:0] {
    EvBegin   = 2'd0,
    EvDone    = 2'd1,
    EvTimeout = 2'd2
  } ev_kind_e;

  // Transaction status codes.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBusy    = 2'd1,
    StIo      = 2'd2,
    StTimeout = 2'd3
  } status_e;

  // Classified input word passed from the front to the back.
  typedef struct packed {
    ev_kind_e               kind;
    logic                   is_read;
    logic [6:0]             addr;
    logic [LenFieldW-1:0]   len;
    logic                   busy;
    logic [7:0]             tx;
    logic                   al;
    logic                   ack;
    logic                   addr_fail;
    logic [7:0]             rx;
  } ev_t;

  // Result word.
  typedef struct packed {
    logic       kind;
    logic       cmd_start;
    logic       cmd_stop;
    logic       cmd_write;
    logic       cmd_read;
    logic       cmd_nack;
    logic [7:0] tx_data;
    logic       rx_valid;
    logic [7:0] rx_data;
    status_e    status;
  } res_t;

endpackage

// ===== hdl/i2cmts_fifo.sv =====
module i2cmts_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         valid_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/i2cmts_front.sv =====
module i2cmts_front import i2cmts_pkg::*; (
  input  logic [1:0]           op_i,
  input  logic [6:0]           dev_addr_i,
  input  logic [LenFieldW-1:0] length_i,
  input  logic                 bus_busy_i,
  input  logic [7:0]           tx_byte_i,
  input  logic                 arb_lost_i,
  input  logic                 rx_ack_i,
  input  logic [7:0]           rx_byte_i,
  output ev_t                  ev_o
);

  // Sort the operation into begin, byte done or timeout.
  always_comb begin
    ev_o = '0;
    case (op_e'(op_i))
      OpBeginWrite: ev_o.kind = EvBegin;
      OpBeginRead:  ev_o.kind = EvBegin;
      OpDone:       ev_o.kind = EvDone;
      OpTimeout:    ev_o.kind = EvTimeout;
      default:      ev_o.kind = EvDone;
    endcase
    ev_o.is_read = (op_e'(op_i) == OpBeginRead);
    ev_o.addr    = dev_addr_i;
    ev_o.len     = length_i;
    ev_o.busy    = bus_busy_i;
    ev_o.tx      = tx_byte_i;
    ev_o.al      = arb_lost_i;
    ev_o.ack     = rx_ack_i;
    ev_o.rx      = rx_byte_i;
    // An address phase fails on lost arbitration, a NACK or a timeout.
    ev_o.addr_fail = arb_lost_i || !rx_ack_i || (op_e'(op_i) == OpTimeout);
  end

endmodule

// ===== hdl/i2cmts_back.sv =====
module i2cmts_back import i2cmts_pkg::*; #(
  parameter int LEN_WIDTH = LenWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RetriesW-1:0] cfg_wdata_i,
  input  logic                ev_valid_i,
  input  ev_t                 ev_i,
  output logic                ev_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output res_t                res_o
);

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhAddr = 4'b0010,
    PhData = 4'b0100,
    PhStop = 4'b1000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic                 is_read_q, is_read_d;
  logic [6:0]           addr_q, addr_d;
  logic [LEN_WIDTH-1:0] bytes_q, bytes_d;
  logic [RetriesW-1:0]  tries_q, tries_d;
  status_e              saved_q, saved_d;
  logic [RetriesW-1:0]  max_retries_q;

  logic [LEN_WIDTH-1:0] len_cut;
  logic [LEN_WIDTH-1:0] bytes_dec;
  logic                 go;
  logic                 has_res;
  logic                 last;
  logic                 want_ack;
  status_e              addr_err;

  // Fit the length field to the byte counter.
  if (LEN_WIDTH > LenFieldW) begin : g_len_wide
    assign len_cut = {{(LEN_WIDTH - LenFieldW){1'b0}}, ev_i.len};
  end else if (LEN_WIDTH == LenFieldW) begin : g_len_same
    assign len_cut = ev_i.len;
  end else begin : g_len_narrow
    assign len_cut = ev_i.len[LEN_WIDTH-1:0];
  end

  // One word is handled per cycle while the result queue has room.
  assign go         = ev_valid_i && !res_full_i;
  assign ev_pop_o   = go;
  assign res_push_o = go && has_res;

  assign bytes_dec = bytes_q - 1'b1;
  assign last      = (bytes_q == '0) || (bytes_q == LEN_WIDTH'(1));
  assign want_ack  = is_read_q ? !last : 1'b1;
  assign addr_err  = (ev_i.kind == EvTimeout) ? StTimeout : StIo;

  // Sequencer step.
  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    addr_d    = addr_q;
    bytes_d   = bytes_q;
    tries_d   = tries_q;
    saved_d   = saved_q;
    has_res   = 1'b0;
    res_o     = '0;
    if (go) begin
      case (ev_i.kind)
        EvBegin: begin
          if (phase_q == PhIdle) begin
            has_res = 1'b1;
            if (ev_i.busy) begin
              res_o.kind   = 1'b1;
              res_o.status = StBusy;
            end else begin
              is_read_d       = ev_i.is_read;
              addr_d          = ev_i.addr;
              bytes_d         = len_cut;
              tries_d         = '0;
              saved_d         = StOk;
              phase_d         = PhAddr;
              res_o.cmd_start = 1'b1;
              res_o.cmd_write = 1'b1;
              res_o.tx_data   = {ev_i.addr, ev_i.is_read};
            end
          end
        end
        EvDone, EvTimeout: begin
          case (phase_q)
            PhAddr: begin
              has_res = 1'b1;
              if (ev_i.addr_fail) begin
                if (tries_q < max_retries_q) begin
                  // Retry the START and address byte.
                  tries_d         = tries_q + 1'b1;
                  res_o.cmd_start = 1'b1;
                  res_o.cmd_write = 1'b1;
                  res_o.tx_data   = {addr_q, is_read_q};
                end else begin
                  saved_d        = addr_err;
                  phase_d        = PhStop;
                  res_o.cmd_stop = 1'b1;
                end
              end else if (bytes_q == '0) begin
                // Nothing to move: close the bus with a STOP.
                saved_d        = StOk;
                phase_d        = PhStop;
                res_o.cmd_stop = 1'b1;
              end else begin
                phase_d        = PhData;
                res_o.cmd_stop = (bytes_q == LEN_WIDTH'(1));
                if (is_read_q) begin
                  res_o.cmd_read = 1'b1;
                  res_o.cmd_nack = (bytes_q == LEN_WIDTH'(1));
                end else begin
                  res_o.cmd_write = 1'b1;
                  res_o.tx_data   = ev_i.tx;
                end
              end
            end
            PhData: begin
              has_res = 1'b1;
              if (ev_i.kind == EvTimeout) begin
                saved_d        = StTimeout;
                phase_d        = PhStop;
                res_o.cmd_stop = 1'b1;
              end else if (ev_i.al || (ev_i.ack != want_ack)) begin
                saved_d        = StIo;
                phase_d        = PhStop;
                res_o.cmd_stop = 1'b1;
              end else begin
                bytes_d = bytes_dec;
                if (last) begin
                  // STOP already went out with the last byte.
                  phase_d      = PhIdle;
                  res_o.kind   = 1'b1;
                  res_o.status = StOk;
                end else begin
                  res_o.cmd_stop = (bytes_dec == LEN_WIDTH'(1));
                  if (is_read_q) begin
                    res_o.cmd_read = 1'b1;
                    res_o.cmd_nack = (bytes_dec == LEN_WIDTH'(1));
                  end else begin
                    res_o.cmd_write = 1'b1;
                    res_o.tx_data   = ev_i.tx;
                  end
                end
                if (is_read_q) begin
                  res_o.rx_valid = 1'b1;
                  res_o.rx_data  = ev_i.rx;
                end
              end
            end
            PhStop: begin
              // The STOP has finished; report what was saved.
              has_res      = 1'b1;
              phase_d      = PhIdle;
              res_o.kind   = 1'b1;
              res_o.status = saved_q;
            end
            default: begin
              has_res = 1'b0;
            end
          endcase
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      is_read_q     <= 1'b0;
      addr_q        <= '0;
      bytes_q       <= '0;
      tries_q       <= '0;
      saved_q       <= StOk;
      max_retries_q <= RetriesReset;
    end else begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      addr_q    <= addr_d;
      bytes_q   <= bytes_d;
      tries_q   <= tries_d;
      saved_q   <= saved_d;
      if (cfg_we_i) begin
        max_retries_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== hdl/i2c_master_transfer_sequencer_unit.sv =====
// I2C master transfer sequencer.
// Input words arrive through a queue interface: a word is taken at a rising
// edge with push high and full low. A begin word (write or read) starts a
// transaction; done and timeout words report what the byte engine did.
// Each taken word gives at most one result word, read from the result side
// while empty is low and taken at an edge with pop high and empty low. A
// result is either a command for the byte engine or a finished word with
// its status.
// A word is decoded into a two-entry event queue; the sequencer handles one
// event per cycle while the result queue has room and writes into a two-entry
// result queue. A result is registered in both queues before it shows on the
// ports; one word per cycle is taken as long as results are drained at that rate.
// When pop stays low the result queue fills, the sequencer holds its
// event, the event queue fills in turn and full rises; nothing is dropped.
// Reset empties both queues, returns the sequencer to idle and sets the
// retry limit to three. The user must write the retry limit through cfg_we_i
// and cfg_wdata_i while no transaction is in progress; it is not enforced.
module i2c_master_transfer_sequencer_unit import i2cmts_pkg::*; #(
  parameter int LEN_WIDTH   = LenWidthDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RetriesW-1:0]  cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           op_i,
  input  logic [6:0]           dev_addr_i,
  input  logic [LenFieldW-1:0] length_i,
  input  logic                 bus_busy_i,
  input  logic [7:0]           tx_byte_i,
  input  logic                 arb_lost_i,
  input  logic                 rx_ack_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 kind_o,
  output logic                 cmd_start_o,
  output logic                 cmd_stop_o,
  output logic                 cmd_write_o,
  output logic                 cmd_read_o,
  output logic                 cmd_nack_o,
  output logic [7:0]           tx_data_o,
  output logic                 rx_valid_o,
  output logic [7:0]           rx_data_o,
  output logic [1:0]           status_o
);

  ev_t  ev_in, ev_head;
  logic ev_valid, ev_pop;
  res_t res_in, res_head;
  logic res_push, res_full, res_valid;

  // Decode of incoming words.
  i2cmts_front u_front (
    .op_i       (op_i),
    .dev_addr_i (dev_addr_i),
    .length_i   (length_i),
    .bus_busy_i (bus_busy_i),
    .tx_byte_i  (tx_byte_i),
    .arb_lost_i (arb_lost_i),
    .rx_ack_i   (rx_ack_i),
    .rx_byte_i  (rx_byte_i),
    .ev_o       (ev_in)
  );

  // Queue between decode and sequencer.
  i2cmts_fifo #(
    .W     ($bits(ev_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ev_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (ev_in),
    .full_o  (full),
    .pop_i   (ev_pop),
    .rdata_o (ev_head),
    .valid_o (ev_valid)
  );

  // Transaction sequencer.
  i2cmts_back #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ev_valid_i  (ev_valid),
    .ev_i        (ev_head),
    .ev_pop_o    (ev_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue toward the receiver.
  i2cmts_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .valid_o (res_valid)
  );

  // Result ports.
  assign empty       = !res_valid;
  assign kind_o      = res_head.kind;
  assign cmd_start_o = res_head.cmd_start;
  assign cmd_stop_o  = res_head.cmd_stop;
  assign cmd_write_o = res_head.cmd_write;
  assign cmd_read_o  = res_head.cmd_read;
  assign cmd_nack_o  = res_head.cmd_nack;
  assign tx_data_o   = res_head.tx_data;
  assign rx_valid_o  = res_head.rx_valid;
  assign rx_data_o   = res_head.rx_data;
  assign status_o    = res_head.status;

  // The sequencer never writes a result into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result written into a full queue");

  // An event is consumed only when one is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ev_pop |-> ev_valid)
    else $error("event consumed from an empty queue");

  // A finished word carries no engine command bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o) |->
      !(cmd_start_o || cmd_stop_o || cmd_write_o || cmd_read_o || cmd_nack_o))
    else $error("finished word carries command bits");

  // A command word carries ok status and write data only with a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !kind_o) |-> (status_o == StOk) && (cmd_write_o || tx_data_o == 8'h00))
    else $error("command word has stray status or data");

endmodule

// ===== sim/i2cmts_transfer_monitor.sv =====
`timescale 1ns / 100ps

// Watches both word channels and the retry-limit port of the sequencer,
// predicts the result word, if any, of every accepted input word and
// compares each popped result word with the oldest prediction.
module i2cmts_transfer_monitor import i2cmts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RetriesW-1:0]  cfg_wdata_i,
  input  logic                 push,
  input  logic                 full,
  input  logic [1:0]           op_i,
  input  logic [6:0]           dev_addr_i,
  input  logic [LenFieldW-1:0] length_i,
  input  logic                 bus_busy_i,
  input  logic [7:0]           tx_byte_i,
  input  logic                 arb_lost_i,
  input  logic                 rx_ack_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic                 kind_o,
  input  logic                 cmd_start_o,
  input  logic                 cmd_stop_o,
  input  logic                 cmd_write_o,
  input  logic                 cmd_read_o,
  input  logic                 cmd_nack_o,
  input  logic [7:0]           tx_data_o,
  input  logic                 rx_valid_o,
  input  logic [7:0]           rx_data_o,
  input  logic [1:0]           status_o,
  output int                   mismatch_count_o,
  output int                   pending_words_o,
  output logic                 running_o,
  output logic                 want_ack_o,
  output logic [LenFieldW-1:0] bytes_left_o
);

  localparam int LenW = LenWidthDefault;
  localparam int ShownMismatches = 50;

  typedef enum logic [1:0] {
    SeqIdle = 2'd0,
    SeqAddr = 2'd1,
    SeqData = 2'd2,
    SeqStop = 2'd3
  } seq_phase_e;

  // Predicted sequencer state and retry limit.
  seq_phase_e          seq_phase = SeqIdle;
  logic                seq_read = 1'b0;
  logic [6:0]          seq_addr = '0;
  logic [LenW-1:0]     seq_left = '0;
  logic [RetriesW-1:0] seq_tries = '0;
  status_e             seq_error = StOk;
  logic [RetriesW-1:0] retry_limit = RetriesReset;

  // Result words predicted but not yet popped, oldest first.
  res_t engine_words_q[$];

  // The stimulus side steers its engine words by the predicted state.
  assign running_o = (seq_phase != SeqIdle);
  assign want_ack_o = (seq_phase == SeqData && seq_read) ? (seq_left > 1) : 1'b1;
  assign bytes_left_o = LenFieldW'(seq_left);

  function automatic res_t engine_cmd(logic sta, logic sto, logic wr, logic rd,
                                      logic nack, logic [7:0] tx);
    res_t r;
    r = '0;
    r.cmd_start = sta;
    r.cmd_stop = sto;
    r.cmd_write = wr;
    r.cmd_read = rd;
    r.cmd_nack = nack;
    r.tx_data = wr ? tx : 8'h00;
    r.status = StOk;
    return r;
  endfunction

  function automatic res_t finished_word(status_e st);
    res_t r;
    r = '0;
    r.kind = 1'b1;
    r.status = st;
    seq_phase = SeqIdle;
    return r;
  endfunction

  function automatic res_t address_cmd();
    return engine_cmd(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, {seq_addr, seq_read});
  endfunction

  // Command for the next data byte; seq_left still counts it.
  function automatic res_t data_cmd(logic [7:0] tx);
    logic last;
    last = (seq_left == 1);
    seq_phase = SeqData;
    if (seq_read) begin
      return engine_cmd(1'b0, last, 1'b0, 1'b1, last, 8'h00);
    end
    return engine_cmd(1'b0, last, 1'b1, 1'b0, 1'b0, tx);
  endfunction

  // Any error ends in a STOP whose completion reports the saved error.
  function automatic res_t abort_cmd(status_e err);
    seq_error = err;
    seq_phase = SeqStop;
    return engine_cmd(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
  endfunction

  // Advances the predicted state by one input word; returns 1 when the word
  // gives a result word, which is then placed in r.
  function automatic bit predict_word(op_e op, logic [6:0] addr, logic [15:0] len,
                                      logic busy, logic [7:0] tx, logic al,
                                      logic ack, logic [7:0] rx, output res_t r);
    logic last;
    logic want;
    status_e err;
    r = '0;
    if (op == OpBeginWrite || op == OpBeginRead) begin
      // A begin word during a running transaction is dropped.
      if (seq_phase != SeqIdle) begin
        return 1'b0;
      end
      if (busy) begin
        r = finished_word(StBusy);
        return 1'b1;
      end
      seq_read = (op == OpBeginRead);
      seq_addr = addr;
      seq_left = len[LenW-1:0];
      seq_tries = '0;
      seq_error = StOk;
      seq_phase = SeqAddr;
      r = address_cmd();
      return 1'b1;
    end
    case (seq_phase)
      SeqAddr: begin
        if (op == OpTimeout || al || !ack) begin
          err = (op == OpTimeout) ? StTimeout : StIo;
          if (seq_tries < retry_limit) begin
            seq_tries = seq_tries + 1'b1;
            r = address_cmd();
          end else begin
            r = abort_cmd(err);
          end
        end else if (seq_left == 0) begin
          // A zero-length transfer still closes with a STOP.
          seq_error = StOk;
          seq_phase = SeqStop;
          r = engine_cmd(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        end else begin
          r = data_cmd(tx);
        end
        return 1'b1;
      end
      SeqData: begin
        last = (seq_left <= 1);
        want = seq_read ? !last : 1'b1;
        if (op == OpTimeout) begin
          r = abort_cmd(StTimeout);
        end else if (al || ack != want) begin
          // The byte of a failed read is not delivered.
          r = abort_cmd(StIo);
        end else begin
          seq_left = seq_left - 1'b1;
          r = last ? finished_word(StOk) : data_cmd(tx);
          if (seq_read) begin
            r.rx_valid = 1'b1;
            r.rx_data = rx;
          end
        end
        return 1'b1;
      end
      SeqStop: begin
        r = finished_word(seq_error);
        return 1'b1;
      end
      default: begin
        // Engine words while idle are dropped.
        return 1'b0;
      end
    endcase
  endfunction

  // Only the first mismatches are printed; all of them are counted.
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count_o++;
    if (mismatch_count_o <= ShownMismatches) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  // Predict on accepted input words, compare on popped result words.
  always @(posedge clk_i) begin
    res_t next_w;
    res_t got_w;
    res_t oldest_w;
    if (!rst_ni) begin
      seq_phase = SeqIdle;
      seq_read = 1'b0;
      seq_addr = '0;
      seq_left = '0;
      seq_tries = '0;
      seq_error = StOk;
      retry_limit = RetriesReset;
      mismatch_count_o = 0;
      engine_words_q.delete();
    end else begin
      if (cfg_we_i) begin
        retry_limit = cfg_wdata_i;
      end
      if (push && !full) begin
        if (predict_word(op_e'(op_i), dev_addr_i, length_i, bus_busy_i, tx_byte_i,
                         arb_lost_i, rx_ack_i, rx_byte_i, next_w)) begin
          engine_words_q.push_back(next_w);
        end
      end
      if (pop && !empty) begin
        got_w = '{kind_o, cmd_start_o, cmd_stop_o, cmd_write_o, cmd_read_o, cmd_nack_o,
                  tx_data_o, rx_valid_o, rx_data_o, status_e'(status_o)};
        if (engine_words_q.size() == 0) begin
          report_mismatch("result word with none expected, kind", got_w.kind, 0);
        end else begin
          oldest_w = engine_words_q.pop_front();
          if (got_w.kind !== oldest_w.kind)
            report_mismatch("kind", got_w.kind, oldest_w.kind);
          if (got_w.cmd_start !== oldest_w.cmd_start)
            report_mismatch("cmd_start", got_w.cmd_start, oldest_w.cmd_start);
          if (got_w.cmd_stop !== oldest_w.cmd_stop)
            report_mismatch("cmd_stop", got_w.cmd_stop, oldest_w.cmd_stop);
          if (got_w.cmd_write !== oldest_w.cmd_write)
            report_mismatch("cmd_write", got_w.cmd_write, oldest_w.cmd_write);
          if (got_w.cmd_read !== oldest_w.cmd_read)
            report_mismatch("cmd_read", got_w.cmd_read, oldest_w.cmd_read);
          if (got_w.cmd_nack !== oldest_w.cmd_nack)
            report_mismatch("cmd_nack", got_w.cmd_nack, oldest_w.cmd_nack);
          if (got_w.tx_data !== oldest_w.tx_data)
            report_mismatch("tx_data", got_w.tx_data, oldest_w.tx_data);
          if (got_w.rx_valid !== oldest_w.rx_valid)
            report_mismatch("rx_valid", got_w.rx_valid, oldest_w.rx_valid);
          if (got_w.rx_data !== oldest_w.rx_data)
            report_mismatch("rx_data", got_w.rx_data, oldest_w.rx_data);
          if (got_w.status !== oldest_w.status)
            report_mismatch("status", got_w.status, oldest_w.status);
        end
      end
    end
    pending_words_o = engine_words_q.size();
  end

endmodule

// ===== sim/i2c_master_transfer_sequencer_unit_test.sv =====
`timescale 1ns / 100ps

// Drives directed and random I2C transactions into the sequencer under
// changing retry limits and idle patterns, and gives the verdict.
module i2c_master_transfer_sequencer_unit_test;
  import i2cmts_pkg::*;

  localparam int PhaseCount = 8;
  localparam int WordsPerPhase = 190;
  localparam int HoldCycles = 80;
  localparam int SettleCycles = 8;
  localparam int WatchLimit = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [RetriesW-1:0]  cfg_wdata_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [1:0]           op_i = OpDone;
  logic [6:0]           dev_addr_i = '0;
  logic [LenFieldW-1:0] length_i = '0;
  logic                 bus_busy_i = 1'b0;
  logic [7:0]           tx_byte_i = '0;
  logic                 arb_lost_i = 1'b0;
  logic                 rx_ack_i = 1'b0;
  logic [7:0]           rx_byte_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 kind_o;
  logic                 cmd_start_o;
  logic                 cmd_stop_o;
  logic                 cmd_write_o;
  logic                 cmd_read_o;
  logic                 cmd_nack_o;
  logic [7:0]           tx_data_o;
  logic                 rx_valid_o;
  logic [7:0]           rx_data_o;
  logic [1:0]           status_o;

  int                   mismatch_count;
  int                   pending_words;
  logic                 seq_running;
  logic                 seq_want_ack;
  logic [LenFieldW-1:0] seq_bytes_left;

  // Idle percentages of both sides, and receiver hold-off requests.
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  i2c_master_transfer_sequencer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .dev_addr_i  (dev_addr_i),
    .length_i    (length_i),
    .bus_busy_i  (bus_busy_i),
    .tx_byte_i   (tx_byte_i),
    .arb_lost_i  (arb_lost_i),
    .rx_ack_i    (rx_ack_i),
    .rx_byte_i   (rx_byte_i),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .cmd_start_o (cmd_start_o),
    .cmd_stop_o  (cmd_stop_o),
    .cmd_write_o (cmd_write_o),
    .cmd_read_o  (cmd_read_o),
    .cmd_nack_o  (cmd_nack_o),
    .tx_data_o   (tx_data_o),
    .rx_valid_o  (rx_valid_o),
    .rx_data_o   (rx_data_o),
    .status_o    (status_o)
  );

  i2cmts_transfer_monitor u_transfer_watch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push             (push),
    .full             (full),
    .op_i             (op_i),
    .dev_addr_i       (dev_addr_i),
    .length_i         (length_i),
    .bus_busy_i       (bus_busy_i),
    .tx_byte_i        (tx_byte_i),
    .arb_lost_i       (arb_lost_i),
    .rx_ack_i         (rx_ack_i),
    .rx_byte_i        (rx_byte_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .cmd_start_o      (cmd_start_o),
    .cmd_stop_o       (cmd_stop_o),
    .cmd_write_o      (cmd_write_o),
    .cmd_read_o       (cmd_read_o),
    .cmd_nack_o       (cmd_nack_o),
    .tx_data_o        (tx_data_o),
    .rx_valid_o       (rx_valid_o),
    .rx_data_o        (rx_data_o),
    .status_o         (status_o),
    .mismatch_count_o (mismatch_count),
    .pending_words_o  (pending_words),
    .running_o        (seq_running),
    .want_ack_o       (seq_want_ack),
    .bytes_left_o     (seq_bytes_left)
  );

  always #5 clk_i = ~clk_i;

  // Ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni && !((push && !full) || (pop && !empty) || cfg_we_i)) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_served = hold_requests;
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one input word, with random idle cycles before it, and returns at
  // the falling edge after it was taken. push stays high for a next word.
  task automatic send_word(op_e op, logic [6:0] addr, logic [15:0] len, logic busy,
                           logic [7:0] tx, logic al, logic ack, logic [7:0] rx);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    dev_addr_i <= addr;
    length_i <= len;
    bus_busy_i <= busy;
    tx_byte_i <= tx;
    arb_lost_i <= al;
    rx_ack_i <= ack;
    rx_byte_i <= rx;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !full;
      @(negedge clk_i);
    end
  endtask

  task automatic send_begin(bit rd, logic [6:0] addr, logic [15:0] len, logic busy);
    send_word(rd ? OpBeginRead : OpBeginWrite, addr, len, busy, $urandom,
              $urandom_range(1), $urandom_range(1), $urandom);
  endtask

  task automatic send_engine(op_e op, logic al, logic ack, logic [7:0] tx, logic [7:0] rx);
    send_word(op, $urandom, $urandom, $urandom_range(1), tx, al, ack, rx);
  endtask

  // Writes the retry limit once all results are out and the block has settled.
  task automatic write_retry_limit(logic [RetriesW-1:0] limit);
    push <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random transaction: mostly good engine words, some errors, some noise.
  task automatic run_transfer();
    bit rd;
    logic [15:0] len;
    int pick;
    if ($urandom_range(99) < 5) begin
      send_engine($urandom_range(1) ? OpDone : OpTimeout, $urandom_range(1),
                  $urandom_range(1), $urandom, $urandom);
    end
    rd = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 65) begin
      len = $urandom_range(4);
    end else if (pick < 90) begin
      len = $urandom_range(24, 5);
    end else begin
      len = $urandom;
    end
    send_begin(rd, $urandom, len, $urandom_range(99) < 8);
    words_sent++;
    while (seq_running) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        // A begin word in the middle of a transaction.
        send_begin($urandom_range(1), $urandom, $urandom, $urandom_range(1));
      end else begin
        pick = $urandom_range(99);
        if (pick < 4 || (seq_bytes_left > 12 && pick < 12)) begin
          send_engine(OpTimeout, $urandom_range(1), $urandom_range(1), $urandom, $urandom);
        end else if (pick < 7) begin
          send_engine(OpDone, 1'b1, $urandom_range(1), $urandom, $urandom);
        end else if (pick < 10) begin
          send_engine(OpDone, 1'b0, !seq_want_ack, $urandom, $urandom);
        end else begin
          send_engine(OpDone, 1'b0, seq_want_ack, $urandom, $urandom);
        end
        words_sent++;
      end
    end
  endtask

  initial begin
    logic [RetriesW-1:0] limits [PhaseCount];
    limits = '{4'd3, 4'd0, 4'd15, 4'd7, 4'd15, 4'd0, 4'd1, 4'd3};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero-length write to the top address; the STOP still goes out.
    send_begin(1'b0, 7'h7f, 16'h0000, 1'b0);
    send_engine(OpDone, 1'b0, 1'b1, 8'hff, 8'hff);
    send_engine(OpDone, 1'b0, 1'b1, 8'h00, 8'h00);
    // Two-byte read from address zero; the last byte is NACKed and kept.
    send_begin(1'b1, 7'h00, 16'd2, 1'b0);
    send_engine(OpDone, 1'b0, 1'b1, 8'h00, 8'h00);
    send_engine(OpDone, 1'b0, 1'b1, 8'h00, 8'haa);
    send_engine(OpDone, 1'b0, 1'b0, 8'hff, 8'h55);
    // Busy bus refuses the begin word at once.
    send_begin(1'b0, 7'h2a, 16'hffff, 1'b1);
    // Engine words while idle are dropped.
    send_engine(OpDone, 1'b0, 1'b1, 8'h12, 8'h34);
    send_engine(OpTimeout, 1'b1, 1'b0, 8'h56, 8'h78);
    // Write with a dropped begin word, then a timeout in the data phase.
    send_begin(1'b0, 7'h55, 16'd2, 1'b0);
    send_begin(1'b1, 7'h11, 16'd1, 1'b0);
    send_engine(OpDone, 1'b0, 1'b1, 8'h00, 8'h00);
    send_engine(OpTimeout, 1'b0, 1'b1, 8'h00, 8'h00);
    send_engine(OpDone, 1'b0, 1'b1, 8'h00, 8'h00);
    // Address phase fails by NACK, lost arbitration and timeout until the
    // three retries are used up.
    send_begin(1'b1, 7'h33, 16'd1, 1'b0);
    send_engine(OpDone, 1'b0, 1'b0, 8'h00, 8'h00);
    send_engine(OpDone, 1'b1, 1'b1, 8'h00, 8'h00);
    send_engine(OpTimeout, 1'b0, 1'b1, 8'h00, 8'h00);
    send_engine(OpDone, 1'b0, 1'b0, 8'h00, 8'h00);
    send_engine(OpTimeout, 1'b0, 1'b0, 8'h00, 8'h00);
    // Last read byte acknowledged by mistake: io error, byte not delivered.
    send_begin(1'b1, 7'h0f, 16'd1, 1'b0);
    send_engine(OpDone, 1'b0, 1'b1, 8'h00, 8'h00);
    send_engine(OpDone, 1'b0, 1'b1, 8'h00, 8'h99);
    send_engine(OpDone, 1'b0, 1'b1, 8'h00, 8'h00);

    // Random phases under different retry limits and idle patterns.
    for (int p = 0; p < PhaseCount; p++) begin
      if (p != 0) begin
        write_retry_limit(limits[p]);
      end
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_requests++;
        end
        1: begin
          idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          idle_pct = 23;
          stall_pct = 23;
        end
      endcase
      while (words_sent < (p + 1) * WordsPerPhase) begin
        run_transfer();
      end
    end

    // Drain and let the block settle before the verdict.
    push <= 1'b0;
    stall_pct = 0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
